### rtl/core/aspl_pkg.sv
// Shared types and constants for the letterbox layout unit.
// No dependencies; imported by every module of the block.
package aspl_pkg;

   localparam int DIM_W   = 14;  // drawable size in whole pixels
   localparam int PIX_W   = 22;  // pixel size in Q.8
   localparam int ASP_W   = 19;  // aspect in Q3.16
   localparam int FRAC_W  = 16;
   localparam int PROD_W  = 41;  // pixel times aspect
   localparam int COORD_W = 24;
   localparam int SIZE_W  = 23;
   localparam int CSR_W   = 2;

   localparam logic [1:0] KIND_PRES = 2'd0;
   localparam logic [1:0] KIND_SAFE = 2'd1;
   localparam logic [1:0] KIND_FULL = 2'd2;

   localparam logic [CSR_W-1:0] CSR_WIDESCREEN = 2'd0;
   localparam logic [CSR_W-1:0] CSR_FORCED     = 2'd1;
   localparam logic [CSR_W-1:0] CSR_LOGICAL    = 2'd2;

   localparam logic [ASP_W-1:0] ASPECT_MIN       = 19'd32768;
   localparam logic [ASP_W-1:0] ASPECT_MAX       = 19'd262144;
   localparam logic [ASP_W-1:0] ASPECT_FIELD_MAX = 19'd524287;
   localparam logic [ASP_W-1:0] LOGICAL_RESET    = 19'd87381;
   localparam logic [SIZE_W-1:0] SIZE_MAX        = 23'd8388607;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sd8388607;
   localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sd8388608;

   typedef struct packed {
      logic [DIM_W-1:0] surf_width;
      logic [DIM_W-1:0] surf_height;
   } req_type;

   typedef struct packed {
      logic [1:0]                rect_kind;
      logic signed [COORD_W-1:0] rect_x;
      logic signed [COORD_W-1:0] rect_y;
      logic [SIZE_W-1:0]         rect_width;
      logic [SIZE_W-1:0]         rect_height;
      logic [ASP_W-1:0]          view_aspect;
      logic                      stretch_mode;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [SIZE_W-1:0]         w;
      logic [SIZE_W-1:0]         h;
   } rect_type;

endpackage

### rtl/core/aspl_div.sv
// Pipelined restoring divider, one quotient bit per stage, sideband carried along.
// Flags overflow when the quotient does not fit QUO_W bits. Uses aspl_pkg.
module aspl_div #(
   parameter int NUM_W  = 38,
   parameter int DEN_W  = 19,
   parameter int QUO_W  = 25,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [QUO_W-1:0]  quo,
   output logic              ovf,
   output logic [SIDE_W-1:0] side_out
);
   import aspl_pkg::*;

   localparam int HI_W  = NUM_W - QUO_W;
   localparam int EXT_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic [EXT_W-1:0]  hi_ext;
   logic [EXT_W-1:0]  den_ext;
   logic              valid_ff [0:QUO_W];
   logic [DEN_W-1:0]  rem_ff   [0:QUO_W];
   logic [QUO_W-1:0]  word_ff  [0:QUO_W];
   logic [DEN_W-1:0]  den_ff   [0:QUO_W];
   logic              ovf_ff   [0:QUO_W];
   logic [SIDE_W-1:0] side_ff  [0:QUO_W];

   assign hi_ext  = EXT_W'(num[NUM_W-1:QUO_W]);
   assign den_ext = EXT_W'(den);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= hi_ext[DEN_W-1:0];
         word_ff[0] <= num[QUO_W-1:0];
         den_ff[0]  <= den;
         ovf_ff[0]  <= (hi_ext >= den_ext);
         side_ff[0] <= side_in;
      end
   end

   for (genvar g = 0; g < QUO_W; g++) begin : g_step
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           take;

      assign trial = {rem_ff[g], word_ff[g][QUO_W-1]};
      assign diff  = trial - {1'b0, den_ff[g]};
      assign take  = (trial >= {1'b0, den_ff[g]});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g+1] <= 1'b0;
         end else if (en) begin
            valid_ff[g+1] <= valid_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g+1]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            word_ff[g+1] <= {word_ff[g][QUO_W-2:0], take};
            den_ff[g+1]  <= den_ff[g];
            ovf_ff[g+1]  <= ovf_ff[g];
            side_ff[g+1] <= side_ff[g];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign quo       = word_ff[QUO_W];
   assign ovf       = ovf_ff[QUO_W];
   assign side_out  = side_ff[QUO_W];

endmodule

### rtl/core/aspect_letterbox_layout_unit.sv
// Letterbox layout unit: drawable size in, presentation/safe/full-bleed rectangles out.
// Depends on aspl_pkg and aspl_div.
//
// Usage:
//   req_*  : one beat per drawable size (valid/ready).
//   rsp_*  : three beats per request, presentation, safe, full-bleed; last marks
//            the full-bleed beat.
//   csr_*  : register writes, ready whenever reset is low; write only while idle.
// Pipeline: the first result beat comes out of the chain of three pipelined dividers
//   (drawable aspect, presentation height, then the safe / full-bleed / aspect divisions
//   in parallel) plus six stages of multiply, compare and select.
// Throughput: the pipeline takes a request every cycle while the output register is empty;
//   the result port drains three beats per request and holds the pipeline until the last.
// Reset: synchronous; clears all valid bits and loads the register defaults
//   (widescreen on, forced aspect 0, logical aspect 4:3).
// Stall: while the output register holds a result, the whole pipeline freezes and
//   req_ready drops until its full-bleed beat is taken; nothing is lost or repeated.
module aspect_letterbox_layout_unit #(
   parameter int DEFAULT_WIDTH  = 320,
   parameter int DEFAULT_HEIGHT = 240
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  aspl_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output aspl_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aspl_pkg::CSR_W-1:0]        csr_index,
   input  logic [aspl_pkg::ASP_W-1:0]        csr_data
);
   import aspl_pkg::*;

   localparam int NUM_W  = PIX_W + FRAC_W;
   localparam int QD_W   = 19;
   localparam int QP_W   = 22;
   localparam int QF_W   = 25;
   localparam int S1_W   = 2 * DIM_W;
   localparam int S2_W   = 3 * PIX_W + 2 + QF_W;
   localparam int SS_W   = 2 * PIX_W;
   localparam int SP_W   = 2 * (PIX_W - 1);
   localparam int SC_W   = 2 * PIX_W + 1 + QF_W;

   logic adv;

   // config registers
   logic             wide_ff;
   logic [ASP_W-1:0] forced_ff;
   logic [ASP_W-1:0] laspect_ff;
   logic             la_zero;

   assign csr_ready = !reset;
   assign la_zero   = (laspect_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff    <= 1'b1;
         forced_ff  <= '0;
         laspect_ff <= LOGICAL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WIDESCREEN: wide_ff    <= csr_data[0];
            CSR_FORCED:     forced_ff  <= csr_data;
            CSR_LOGICAL:    laspect_ff <= csr_data;
            default: ;
         endcase
      end
   end

   function automatic logic signed [COORD_W-1:0] half_sat(input logic signed [25:0] d);
      logic signed [25:0] hv;
      hv = (d + $signed({25'b0, d[25]})) >>> 1;
      if (hv < -26'sd8388608) return COORD_MIN;
      else if (hv > 26'sd8388607) return COORD_MAX;
      else return hv[COORD_W-1:0];
   endfunction

   // ---- s0: input register
   logic             v0_ff;
   logic [DIM_W-1:0] pw0_ff, ph0_ff;

   assign req_ready = adv && !reset;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (adv) v0_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pw0_ff <= (req_data.surf_width == '0) ? DIM_W'(DEFAULT_WIDTH)
                                                 : req_data.surf_width;
         ph0_ff <= (req_data.surf_height == '0) ? DIM_W'(DEFAULT_HEIGHT)
                                                  : req_data.surf_height;
      end
   end

   // ---- drawable aspect division
   logic             v1d;
   logic [QD_W-1:0]  q1;
   logic             ovf1;
   logic [S1_W-1:0]  side1;

   aspl_div #(.NUM_W(DIM_W + FRAC_W), .DEN_W(DIM_W), .QUO_W(QD_W), .SIDE_W(S1_W))
   u_div_asp (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v0_ff),
      .num({pw0_ff, 16'b0}), .den(ph0_ff), .side_in({pw0_ff, ph0_ff}),
      .out_valid(v1d), .quo(q1), .ovf(ovf1), .side_out(side1)
   );

   // ---- s1: clamp aspect
   logic             v1_ff;
   logic [ASP_W-1:0] asp1_ff, asp_raw, asp1_in;
   logic [PIX_W-1:0] w1_ff, h1_ff;

   always_comb begin
      if (forced_ff != '0) asp_raw = forced_ff;
      else if (ovf1)       asp_raw = ASPECT_MAX;
      else                 asp_raw = q1;
      if (asp_raw < ASPECT_MIN)      asp1_in = ASPECT_MIN;
      else if (asp_raw > ASPECT_MAX) asp1_in = ASPECT_MAX;
      else                           asp1_in = asp_raw;
   end

   // ---- s2: products, s3: compares
   logic              v2_ff, v3_ff;
   logic [ASP_W-1:0]  asp2_ff, asp3_ff;
   logic [PIX_W-1:0]  w2_ff, h2_ff, w3_ff, h3_ff;
   logic [PROD_W-1:0] prod2_ff, cprod2_ff;
   logic              wider3_ff, cwider3_ff;
   logic [PIX_W-1:0]  cand3_ff;
   logic [QF_W-1:0]   cwcand3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v1d;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         asp1_ff    <= asp1_in;
         w1_ff      <= {side1[S1_W-1:DIM_W], 8'b0};
         h1_ff      <= {side1[DIM_W-1:0], 8'b0};
         prod2_ff   <= PROD_W'(h1_ff) * PROD_W'(asp1_ff);
         cprod2_ff  <= PROD_W'(h1_ff) * PROD_W'(laspect_ff);
         asp2_ff    <= asp1_ff;
         w2_ff      <= w1_ff;
         h2_ff      <= h1_ff;
         wider3_ff  <= {3'b0, w2_ff, 16'b0} > prod2_ff;
         cwider3_ff <= {3'b0, w2_ff, 16'b0} > cprod2_ff;
         cand3_ff   <= prod2_ff[NUM_W-1:FRAC_W];
         cwcand3_ff <= cprod2_ff[PROD_W-1:FRAC_W];
         asp3_ff    <= asp2_ff;
         w3_ff      <= w2_ff;
         h3_ff      <= h2_ff;
      end
   end

   // ---- presentation height division
   logic             v2d;
   logic [QP_W-1:0]  q2;
   logic             ovf2;
   logic [S2_W-1:0]  side2;

   aspl_div #(.NUM_W(NUM_W), .DEN_W(ASP_W), .QUO_W(QP_W), .SIDE_W(S2_W)) u_div_pres (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v3_ff),
      .num({w3_ff, 16'b0}), .den(asp3_ff),
      .side_in({w3_ff, h3_ff, wider3_ff, cand3_ff, cwider3_ff, cwcand3_ff}),
      .out_valid(v2d), .quo(q2), .ovf(ovf2), .side_out(side2)
   );

   // ---- s4: presentation box
   logic [PIX_W-1:0]   w4s, h4s, cand4s, dw4, dh4;
   logic               wider4s, cwider4s;
   logic [QF_W-1:0]    cwcand4s;
   logic               v4_ff, cwider4_ff;
   logic [PIX_W-1:0]   w4_ff, h4_ff, pres_w4_ff, pres_h4_ff;
   logic [PIX_W-2:0]   px4_ff, py4_ff;
   logic [QF_W-1:0]    cwcand4_ff;

   assign {w4s, h4s, wider4s, cand4s, cwider4s, cwcand4s} = side2;
   assign dw4 = w4s - cand4s;
   assign dh4 = h4s - q2;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v2d;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w4_ff      <= w4s;
         h4_ff      <= h4s;
         cwider4_ff <= cwider4s;
         cwcand4_ff <= cwcand4s;
         // quotient fits: without the wider case it never exceeds the height
         if (wider4s || ovf2) begin
            pres_w4_ff <= cand4s;
            pres_h4_ff <= h4s;
            px4_ff     <= dw4[PIX_W-1:1];
            py4_ff     <= '0;
         end else begin
            pres_w4_ff <= w4s;
            pres_h4_ff <= q2;
            px4_ff     <= '0;
            py4_ff     <= dh4[PIX_W-1:1];
         end
      end
   end

   // ---- safe height, full-bleed height and presentation aspect divisions
   logic             vS, vC, vP, ovfS, ovfC, ovfP;
   logic [QF_W-1:0]  qS, qC, qP;
   logic [SS_W-1:0]  sideS;
   logic [SC_W-1:0]  sideC;
   logic [SP_W-1:0]  sideP;

   aspl_div #(.NUM_W(NUM_W), .DEN_W(ASP_W), .QUO_W(QF_W), .SIDE_W(SS_W)) u_div_safe (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v4_ff),
      .num({pres_w4_ff, 16'b0}), .den(laspect_ff), .side_in({pres_w4_ff, pres_h4_ff}),
      .out_valid(vS), .quo(qS), .ovf(ovfS), .side_out(sideS)
   );

   aspl_div #(.NUM_W(NUM_W), .DEN_W(ASP_W), .QUO_W(QF_W), .SIDE_W(SC_W)) u_div_full (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v4_ff),
      .num({w4_ff, 16'b0}), .den(laspect_ff),
      .side_in({w4_ff, h4_ff, cwider4_ff, cwcand4_ff}),
      .out_valid(vC), .quo(qC), .ovf(ovfC), .side_out(sideC)
   );

   aspl_div #(.NUM_W(NUM_W), .DEN_W(PIX_W), .QUO_W(QF_W), .SIDE_W(SP_W)) u_div_pasp (
      .clock(clock), .reset(reset), .en(adv), .in_valid(v4_ff),
      .num({pres_w4_ff, 16'b0}), .den(pres_h4_ff), .side_in({px4_ff, py4_ff}),
      .out_valid(vP), .quo(qP), .ovf(ovfP), .side_out(sideP)
   );

   // ---- s5: full-bleed box, presentation aspect, safe product
   logic [PIX_W-1:0]  pw5s, ph5s, w5s, h5s;
   logic [PIX_W-2:0]  px5s, py5s;
   logic              cw5s;
   logic [QF_W-1:0]   cwc5s;
   rect_type          full5_in;
   logic [SIZE_W-1:0] ch_sat, cw_sat;

   assign {pw5s, ph5s}           = sideS;
   assign {w5s, h5s, cw5s, cwc5s} = sideC;
   assign {px5s, py5s}           = sideP;
   assign ch_sat = (qC > QF_W'(SIZE_MAX)) ? SIZE_MAX : qC[SIZE_W-1:0];
   assign cw_sat = (cwc5s > QF_W'(SIZE_MAX)) ? SIZE_MAX : cwc5s[SIZE_W-1:0];

   always_comb begin
      full5_in.x = '0;
      full5_in.y = '0;
      full5_in.w = SIZE_W'(w5s);
      full5_in.h = SIZE_W'(h5s);
      if (!la_zero) begin
         if (cw5s) begin
            if (ovfC) begin
               full5_in.h = SIZE_MAX;
               full5_in.y = COORD_MIN;
            end else begin
               full5_in.h = ch_sat;
               full5_in.y = half_sat(26'(h5s) - 26'(qC));
            end
         end else begin
            full5_in.w = cw_sat;
            full5_in.x = half_sat(26'(w5s) - 26'(cwc5s));
         end
      end
   end

   logic              v5_ff;
   rect_type          pres5_ff, full5_ff;
   logic [PIX_W-1:0]  pres_w5_ff, pres_h5_ff, w5_ff, h5_ff, qs5_ff;
   logic [PIX_W-2:0]  px5_ff, py5_ff;
   logic [PROD_W-1:0] sprod5_ff;
   logic [ASP_W-1:0]  pasp5_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= vS & vC & vP;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pres5_ff   <= '{x: COORD_W'(px5s), y: COORD_W'(py5s),
                         w: SIZE_W'(pw5s), h: SIZE_W'(ph5s)};
         full5_ff   <= full5_in;
         pres_w5_ff <= pw5s;
         pres_h5_ff <= ph5s;
         px5_ff     <= px5s;
         py5_ff     <= py5s;
         w5_ff      <= w5s;
         h5_ff      <= h5s;
         qs5_ff     <= (ovfS || qS[QF_W-1:PIX_W] != '0) ? '1 : qS[PIX_W-1:0];
         sprod5_ff  <= PROD_W'(ph5s) * PROD_W'(laspect_ff);
         pasp5_ff   <= (ovfP || qP > QF_W'(ASPECT_FIELD_MAX)) ? ASPECT_FIELD_MAX
                                                               : qP[ASP_W-1:0];
      end
   end

   // ---- safe box, legacy select, output register
   rect_type         safe_in, draw_rect;
   logic             swider;
   logic [PIX_W-1:0] sw_c, sdw, sdh, sx_c, sy_c;

   assign swider = {3'b0, pres_w5_ff, 16'b0} > sprod5_ff;
   assign sw_c   = sprod5_ff[NUM_W-1:FRAC_W];
   assign sdw    = pres_w5_ff - sw_c;
   assign sdh    = pres_h5_ff - qs5_ff;
   assign sx_c   = PIX_W'(px5_ff) + PIX_W'(sdw[PIX_W-1:1]);
   assign sy_c   = PIX_W'(py5_ff) + PIX_W'(sdh[PIX_W-1:1]);
   assign draw_rect = '{x: '0, y: '0, w: SIZE_W'(w5_ff), h: SIZE_W'(h5_ff)};

   always_comb begin
      safe_in = pres5_ff;
      if (!la_zero) begin
         if (swider) begin
            safe_in.w = SIZE_W'(sw_c);
            safe_in.x = COORD_W'(sx_c);
         end else begin
            safe_in.h = SIZE_W'(qs5_ff);
            safe_in.y = COORD_W'(sy_c);
         end
      end
   end

   logic             ser_valid_ff;
   logic [1:0]       cnt_ff;
   rect_type         pres_ff, safe_ff, full_ff, sel_rect;
   logic [ASP_W-1:0] pasp_ff;
   logic             legacy_ff;

   assign adv = !ser_valid_ff || (rsp_ready && cnt_ff == KIND_FULL);

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         cnt_ff       <= KIND_PRES;
      end else if (adv) begin
         ser_valid_ff <= v5_ff;
         cnt_ff       <= KIND_PRES;
      end else if (rsp_ready) begin
         cnt_ff <= cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (wide_ff) begin
            pres_ff   <= pres5_ff;
            safe_ff   <= safe_in;
            full_ff   <= full5_ff;
            pasp_ff   <= pasp5_ff;
            legacy_ff <= 1'b0;
         end else begin
            pres_ff   <= draw_rect;
            safe_ff   <= draw_rect;
            full_ff   <= draw_rect;
            pasp_ff   <= laspect_ff;
            legacy_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      case (cnt_ff)
         KIND_PRES: sel_rect = pres_ff;
         KIND_SAFE: sel_rect = safe_ff;
         default:   sel_rect = full_ff;
      endcase
   end

   assign rsp_valid             = ser_valid_ff;
   assign rsp_data.rect_kind    = cnt_ff;
   assign rsp_data.rect_x       = sel_rect.x;
   assign rsp_data.rect_y       = sel_rect.y;
   assign rsp_data.rect_width   = sel_rect.w;
   assign rsp_data.rect_height  = sel_rect.h;
   assign rsp_data.view_aspect  = pasp_ff;
   assign rsp_data.stretch_mode = legacy_ff;
   assign rsp_data.last         = (cnt_ff == KIND_FULL);

endmodule

### rtl/core/aspl_checker.sv
// Port-level checks for the letterbox layout unit, bound to the top level.
// Depends on aspl_pkg.
module aspl_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input aspl_pkg::rsp_type          rsp_data
);
   import aspl_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.rect_kind == KIND_PRES
      |=> rsp_valid && rsp_data.rect_kind == KIND_SAFE)
      else $error("safe beat does not follow presentation beat");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (rsp_data.rect_kind == KIND_FULL)))
      else $error("last flag off the full-bleed beat");

   a_legacy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stretch_mode |-> rsp_data.rect_x == 0 && rsp_data.rect_y == 0)
      else $error("legacy rectangle not at origin");

endmodule

bind aspect_letterbox_layout_unit aspl_checker u_aspl_checker (.*);

### tb/sv/aspect_letterbox_layout_unit_test.sv
// Self-checking bench for aspect_letterbox_layout_unit: random and directed drawable sizes,
// register phases, three rectangles per request checked against an in-bench layout predictor.
// Depends on aspl_pkg and the unit's RTL.
`timescale 1ns / 1ps

module aspect_letterbox_layout_unit_test;
   import aspl_pkg::*;

   localparam int LW = 320;
   localparam int LH = 240;
   localparam int DRAIN_CYCLES = 120;
   localparam logic [CSR_W-1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_W-1:0] csr_index = CSR_WIDESCREEN;
   logic [ASP_W-1:0] csr_data = '0;

   aspect_letterbox_layout_unit u_top (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the registers
   logic             wide_on = 1'b1;
   logic [ASP_W-1:0] forced_asp = '0;
   logic [ASP_W-1:0] logical_asp = LOGICAL_RESET;

   req_type size_queue[$];
   rsp_type rect_queue[$];
   int errors = 0;

   typedef struct {
      longint x, y, w, h;
   } box_type;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic box_type fit_or_cover(longint w, longint h, longint a, bit covering);
      box_type r;
      bit wider;
      r = '{0, 0, w, h};
      if (a == 0 || w <= 0 || h <= 0) return r;
      wider = (w * 65536) > (a * h);
      if (wider ^ covering) begin
         r.w = (h * a) >>> 16;
         r.x = (w - r.w) / 2;
      end else begin
         r.h = (w <<< 16) / a;
         r.y = (h - r.h) / 2;
      end
      return r;
   endfunction

   function automatic rsp_type rect_beat(logic [1:0] kind, box_type b, longint asp, bit legacy);
      rsp_type o;
      longint v;
      o.rect_kind = kind;
      v = b.x; if (v > 8388607) v = 8388607; if (v < -8388608) v = -8388608;
      o.rect_x = v[COORD_W-1:0];
      v = b.y; if (v > 8388607) v = 8388607; if (v < -8388608) v = -8388608;
      o.rect_y = v[COORD_W-1:0];
      v = b.w; if (v < 0) v = 0; if (v > 8388607) v = 8388607;
      o.rect_width = v[SIZE_W-1:0];
      v = b.h; if (v < 0) v = 0; if (v > 8388607) v = 8388607;
      o.rect_height = v[SIZE_W-1:0];
      o.view_aspect = asp[ASP_W-1:0];
      o.stretch_mode = legacy;
      o.last = (kind == KIND_FULL);
      return o;
   endfunction

   task automatic predict_layout(req_type d);
      longint pw, ph, w, h, asp, pasp;
      box_type drw, pres, safe, full;
      pw = d.surf_width;
      ph = d.surf_height;
      if (pw == 0) pw = LW;
      if (ph == 0) ph = LH;
      w = pw << 8;
      h = ph << 8;
      drw = '{0, 0, w, h};
      if (!wide_on) begin
         rect_queue.push_back(rect_beat(KIND_PRES, drw, logical_asp, 1));
         rect_queue.push_back(rect_beat(KIND_SAFE, drw, logical_asp, 1));
         rect_queue.push_back(rect_beat(KIND_FULL, drw, logical_asp, 1));
         return;
      end
      asp = forced_asp;
      if (asp == 0) asp = (pw << 16) / ph;
      if (asp < ASPECT_MIN) asp = ASPECT_MIN;
      if (asp > ASPECT_MAX) asp = ASPECT_MAX;
      pres = fit_or_cover(w, h, asp, 0);
      safe = fit_or_cover(pres.w, pres.h, logical_asp, 0);
      safe.x += pres.x;
      safe.y += pres.y;
      full = fit_or_cover(w, h, logical_asp, 1);
      if (pres.h > 0 && pres.w >= 0) begin
         pasp = (pres.w << 16) / pres.h;
         if (pasp > 524287) pasp = 524287;
      end else begin
         pasp = 0;
      end
      rect_queue.push_back(rect_beat(KIND_PRES, pres, pasp, 0));
      rect_queue.push_back(rect_beat(KIND_SAFE, safe, pasp, 0));
      rect_queue.push_back(rect_beat(KIND_FULL, full, pasp, 0));
   endtask

   // request driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_layout(req_data);
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (size_queue.size() > 0) begin
               req_data <= size_queue.pop_front();
               req_valid <= 1'b1;
               req_gap = gap_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and stall generator
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rect_queue.size() == 0) begin
               $error("unexpected result beat kind=%0d", rsp_data.rect_kind);
               errors++;
            end else begin
               rsp_type e;
               e = rect_queue.pop_front();
               if (e.rect_kind !== rsp_data.rect_kind) begin
                  $error("rect_kind exp %0d got %0d", e.rect_kind, rsp_data.rect_kind);
                  errors++;
               end
               if (e.rect_x !== rsp_data.rect_x) begin
                  $error("rect_x exp %0d got %0d", e.rect_x, rsp_data.rect_x);
                  errors++;
               end
               if (e.rect_y !== rsp_data.rect_y) begin
                  $error("rect_y exp %0d got %0d", e.rect_y, rsp_data.rect_y);
                  errors++;
               end
               if (e.rect_width !== rsp_data.rect_width) begin
                  $error("rect_width exp %0d got %0d", e.rect_width, rsp_data.rect_width);
                  errors++;
               end
               if (e.rect_height !== rsp_data.rect_height) begin
                  $error("rect_height exp %0d got %0d", e.rect_height, rsp_data.rect_height);
                  errors++;
               end
               if (e.view_aspect !== rsp_data.view_aspect) begin
                  $error("view_aspect exp %0d got %0d",
                         e.view_aspect, rsp_data.view_aspect);
                  errors++;
               end
               if (e.stretch_mode !== rsp_data.stretch_mode) begin
                  $error("stretch_mode exp %0d got %0d",
                         e.stretch_mode, rsp_data.stretch_mode);
                  errors++;
               end
               if (e.last !== rsp_data.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_data.last);
                  errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) rsp_gap = gap_len();
         end
      end
   end

   task automatic csr_write(logic [CSR_W-1:0] idx, logic [ASP_W-1:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_WIDESCREEN: wide_on = val[0];
         CSR_FORCED:     forced_asp = val;
         CSR_LOGICAL:    logical_asp = val;
         default: ;
      endcase
   endtask

   // wait for every queued size to be taken and all rectangles back
   task automatic drain();
      while (size_queue.size() != 0 || req_valid) @(posedge clock);
      while (rect_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_type rand_size();
      req_type d;
      int r;
      r = $urandom_range(0, 9);
      d.surf_width = DIM_W'($urandom_range(0, 16383));
      d.surf_height = DIM_W'($urandom_range(0, 16383));
      if (r < 4) begin
         d.surf_width = DIM_W'($urandom_range(1, 4000));
         d.surf_height = DIM_W'($urandom_range(1, 3000));
      end else if (r == 4) begin
         d.surf_width = '0;
      end else if (r == 5) begin
         d.surf_height = '0;
      end
      return d;
   endfunction

   task automatic random_phase(int n);
      repeat (n) size_queue.push_back(rand_size());
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, default sizes, odd aspects
      size_queue.push_back('{14'd0, 14'd0});
      size_queue.push_back('{14'd16383, 14'd16383});
      size_queue.push_back('{14'd16383, 14'd1});
      size_queue.push_back('{14'd1, 14'd16383});
      size_queue.push_back('{14'd1, 14'd1});
      size_queue.push_back('{14'd1920, 14'd1080});
      size_queue.push_back('{14'd640, 14'd480});
      size_queue.push_back('{14'd0, 14'd16383});
      size_queue.push_back('{14'd16383, 14'd0});
      size_queue.push_back('{14'h2aaa, 14'h1555});
      size_queue.push_back('{14'h1555, 14'h2aaa});
      drain();
      csr_write(CSR_WIDESCREEN, 19'd0);
      size_queue.push_back('{14'd0, 14'd0});
      size_queue.push_back('{14'd16383, 14'd16383});
      size_queue.push_back('{14'd800, 14'd600});
      drain();
      random_phase(10);
      csr_write(CSR_WIDESCREEN, 19'd1);
      csr_write(CSR_FORCED, ASPECT_MAX);
      csr_write(CSR_LOGICAL, ASPECT_MIN);
      size_queue.push_back('{14'd16383, 14'd16383});
      size_queue.push_back('{14'd1, 14'd16383});
      random_phase(25);
      csr_write(CSR_FORCED, 19'd1);            // clamps up to the minimum
      csr_write(CSR_LOGICAL, ASPECT_MAX);
      random_phase(20);
      csr_write(CSR_FORCED, 19'h7ffff);        // clamps down to the maximum
      csr_write(CSR_LOGICAL, 19'h7ffff);       // out of range, saturates
      random_phase(15);
      csr_write(CSR_LOGICAL, 19'd0);           // zero aspect: fit/cover give the outer box
      size_queue.push_back('{14'd16383, 14'd16383});
      random_phase(15);
      csr_write(CSR_UNUSED, 19'h12345);        // unused index, ignored
      csr_write(CSR_FORCED, 19'd0);
      csr_write(CSR_LOGICAL, LOGICAL_RESET);
      random_phase(28);
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

### files.f
rtl/core/aspl_pkg.sv
rtl/core/aspl_div.sv
rtl/core/aspect_letterbox_layout_unit.sv
rtl/core/aspl_checker.sv
tb/sv/aspect_letterbox_layout_unit_test.sv
